FILE: rtl/i2cm_pkg.sv
`timescale 1ns / 1ps
package i2cm_pkg;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_BITLO = 3'd2;
  localparam logic [2:0] PH_BITHI = 3'd3;
  localparam logic [2:0] PH_STOP  = 3'd4;

  localparam logic [2:0] CMD_NONE   = 3'd0;
  localparam logic [2:0] CMD_START  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_WRITE  = 3'd3;
  localparam logic [2:0] CMD_RDACK  = 3'd4;
  localparam logic [2:0] CMD_RDNACK = 3'd5;
  localparam logic [2:0] CMD_PROBE  = 3'd6;
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  localparam logic [7:0] MSB_MASK      = 8'h80;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
  } out_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [3:0] bit_count;
    logic [7:0] shift_reg;
    logic [2:0] active_cmd;
    logic [7:0] rx_reg;
    logic       ack_flag;
    logic       scl_reg;
    logic       sda_reg;
  } st_t;

endpackage

FILE: rtl/i2c_master_bit_engine_unit.sv
`timescale 1ns / 1ps
// I2C master bus sequencer. Each accepted word is one bus phase tick (sampled SDA plus,
// when idle, a new command) and yields exactly one result word in the next cycle. A word
// can be taken every cycle as long as the output register is empty or is read in that
// same cycle; a result left waiting holds off the input until it is taken. The
// sequencer state register is updated only on an accepted word. On the bus, start and
// stop take 3 ticks, write and read 18 ticks and probe 24 ticks.
module i2c_master_bit_engine_unit
  import i2cm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  st_t  st_r;
  st_t  st_nxt;
  out_t res_nxt;
  out_t out_r;
  logic out_valid_r;
  logic in_acc;

  i2cm_step u_step (
    .st_i  (st_r),
    .in_i  (in_data),
    .st_o  (st_nxt),
    .res_o (res_nxt)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_IDLE;
      st_r.bit_count  <= '0;
      st_r.shift_reg  <= '0;
      st_r.active_cmd <= CMD_NONE;
      st_r.rx_reg     <= '0;
      st_r.ack_flag   <= 1'b0;
      st_r.scl_reg    <= 1'b1;
      st_r.sda_reg    <= 1'b1;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.done_res |-> out_r.busy_res)
    else $error("done without busy");

  a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && st_r.phase == PH_IDLE && (in_data.cmd == CMD_NONE || in_data.cmd == CMD_UNUSED)
    |=> !out_r.busy_res && $stable(st_r))
    else $error("idle tick changed state");

  a_acc_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted word produced no result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(st_r))
    else $error("state moved without accept");

  a_bitcnt: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bit_count <= BITS_PER_BYTE)
    else $error("bit counter overrun");

endmodule

FILE: rtl/i2cm_step.sv
`timescale 1ns / 1ps
module i2cm_step
  import i2cm_pkg::*;
(
  input  st_t  st_i,
  input  in_t  in_i,
  output st_t  st_o,
  output out_t res_o
);

  st_t  s;
  logic busy;
  logic done;
  logic rd;

  always_comb begin
    s    = st_i;
    busy = 1'b0;
    done = 1'b0;

    if (s.phase > PH_STOP) begin
      s.phase = PH_IDLE;
    end

    // command is taken only while idle, first tick runs right away
    if (s.phase == PH_IDLE && (in_i.cmd inside {[CMD_START:CMD_PROBE]})) begin
      s.active_cmd = in_i.cmd;
      s.bit_count  = '0;
      s.shift_reg  = (in_i.cmd == CMD_WRITE || in_i.cmd == CMD_PROBE) ? in_i.tx_byte : 8'd0;
      if (in_i.cmd == CMD_START || in_i.cmd == CMD_PROBE) begin
        s.phase = PH_START;
      end else if (in_i.cmd == CMD_STOP) begin
        s.phase = PH_STOP;
      end else begin
        s.phase = PH_BITLO;
      end
    end

    rd = (s.active_cmd == CMD_RDACK) || (s.active_cmd == CMD_RDNACK);

    case (s.phase)
      PH_START: begin
        busy = 1'b1;
        if (s.bit_count == 4'd0) begin
          s.scl_reg = 1'b1; s.sda_reg = 1'b1; s.bit_count = 4'd1;
        end else if (s.bit_count == 4'd1) begin
          s.scl_reg = 1'b1; s.sda_reg = 1'b0; s.bit_count = 4'd2;
        end else begin
          s.scl_reg = 1'b0; s.sda_reg = 1'b0; s.bit_count = 4'd0;
          if (s.active_cmd == CMD_PROBE) begin
            s.phase = PH_BITLO;
          end else begin
            s.phase = PH_IDLE;
            done    = 1'b1;
          end
        end
      end
      PH_BITLO: begin
        busy      = 1'b1;
        s.scl_reg = 1'b0;
        if (s.bit_count < BITS_PER_BYTE) begin
          s.sda_reg = rd ? 1'b1 : ((s.shift_reg & MSB_MASK) != 8'd0);
        end else begin
          // ack slot: released for write, probe and read with nack, driven low for read with ack
          s.sda_reg = (s.active_cmd != CMD_RDACK);
        end
        s.phase = PH_BITHI;
      end
      PH_BITHI: begin
        busy      = 1'b1;
        s.scl_reg = 1'b1;
        if (s.bit_count < BITS_PER_BYTE) begin
          s.shift_reg = {s.shift_reg[6:0], rd & in_i.sda_in};
          s.bit_count = s.bit_count + 4'd1;
          s.phase     = PH_BITLO;
        end else begin
          s.bit_count = '0;
          if (s.active_cmd == CMD_PROBE) begin
            s.ack_flag = in_i.sda_in;
            s.phase    = PH_STOP;
          end else begin
            if (rd) begin
              s.rx_reg = s.shift_reg;
            end
            s.phase = PH_IDLE;
            done    = 1'b1;
          end
        end
      end
      PH_STOP: begin
        busy = 1'b1;
        if (s.bit_count == 4'd0) begin
          s.scl_reg = 1'b0; s.sda_reg = 1'b0; s.bit_count = 4'd1;
        end else if (s.bit_count == 4'd1) begin
          s.scl_reg = 1'b1; s.sda_reg = 1'b0; s.bit_count = 4'd2;
        end else begin
          s.scl_reg = 1'b1; s.sda_reg = 1'b1; s.bit_count = 4'd0;
          s.phase   = PH_IDLE;
          done      = 1'b1;
        end
      end
      default: begin
      end
    endcase

    st_o            = s;
    res_o.scl_level = s.scl_reg;
    res_o.sda_level = s.sda_reg;
    res_o.busy_res  = busy;
    res_o.done_res  = done;
    res_o.rx_byte   = s.rx_reg;
    res_o.no_ack    = s.ack_flag;
  end

endmodule
